FILE: rtl/mfna_pkg.sv
// ============================================================================
// mfna_pkg
// Shared types, codes and arithmetic helpers for the mirror fold block.
// ============================================================================
package mfna_pkg;

    localparam int COORD_W = 32;
    localparam int NQ      = 10;

    // Rounded quaternion products, in the order the matrix is built from them
    localparam logic [3:0] Q_L2 = 4'd0;
    localparam logic [3:0] Q_M2 = 4'd1;
    localparam logic [3:0] Q_V2 = 4'd2;
    localparam logic [3:0] Q_P2 = 4'd3;
    localparam logic [3:0] Q_LM = 4'd4;
    localparam logic [3:0] Q_VP = 4'd5;
    localparam logic [3:0] Q_VL = 4'd6;
    localparam logic [3:0] Q_MP = 4'd7;
    localparam logic [3:0] Q_MV = 4'd8;
    localparam logic [3:0] Q_LP = 4'd9;

    typedef enum logic [2:0] {
        CFG_QUAT_L,
        CFG_QUAT_M,
        CFG_QUAT_V,
        CFG_QUAT_P,
        CFG_SCALE,
        CFG_MIN_NORM
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAT,
        ST_ROT,
        ST_SCL,
        ST_WRITE,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_SQ_RD,
        ST_SQ,
        ST_SQ_END,
        ST_SQRT,
        ST_NORM,
        ST_OUT_RD,
        ST_OUT_GO,
        ST_OUT_WAIT,
        ST_EMIT
    } back_state_t;

    typedef struct packed {
        logic signed [31:0] quat_l;
        logic signed [31:0] quat_m;
        logic signed [31:0] quat_v;
        logic signed [31:0] quat_p;
        logic        [30:0] scale_factor;
        logic        [30:0] min_norm;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] orig_x;
        logic signed [31:0] orig_y;
        logic signed [31:0] orig_z;
        logic signed [31:0] mirror_x;
        logic signed [31:0] mirror_y;
        logic signed [31:0] mirror_z;
        logic               last_atom;
    } atom_t;

    typedef logic signed [34:0] qarr_t [NQ];

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    // round to nearest by 2^30, ties toward plus infinity
    function automatic logic signed [35:0] rnd30(input logic signed [65:0] x);
        logic signed [65:0] t;
        t = x + 66'sd536870912;
        return t[65:30];
    endfunction

    // entry r[i][j] of the rotation matrix, e = 3*i + j
    function automatic logic signed [31:0] mat_entry(input qarr_t q, input logic [3:0] e);
        logic signed [37:0] t;
        case (e)
            4'd0:    t = 38'(q[Q_L2]) - 38'(q[Q_M2]) - 38'(q[Q_V2]) + 38'(q[Q_P2]);
            4'd1:    t = (38'(q[Q_LM]) - 38'(q[Q_VP])) <<< 1;
            4'd2:    t = (38'(q[Q_VL]) + 38'(q[Q_MP])) <<< 1;
            4'd3:    t = (38'(q[Q_LM]) + 38'(q[Q_VP])) <<< 1;
            4'd4:    t = 38'(q[Q_M2]) - 38'(q[Q_V2]) - 38'(q[Q_L2]) + 38'(q[Q_P2]);
            4'd5:    t = (38'(q[Q_MV]) - 38'(q[Q_LP])) <<< 1;
            4'd6:    t = (38'(q[Q_VL]) - 38'(q[Q_MP])) <<< 1;
            4'd7:    t = (38'(q[Q_MV]) + 38'(q[Q_LP])) <<< 1;
            4'd8:    t = 38'(q[Q_V2]) - 38'(q[Q_L2]) - 38'(q[Q_M2]) + 38'(q[Q_P2]);
            default: t = '0;
        endcase
        return sat32(64'(t));
    endfunction

endpackage

FILE: rtl/mfna_if.sv
// ============================================================================
// mfna_if
// Valid/ready channels for atom words and result words.
// ============================================================================
interface mfna_atom_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] orig_x;
    logic signed [31:0] orig_y;
    logic signed [31:0] orig_z;
    logic signed [31:0] mirror_x;
    logic signed [31:0] mirror_y;
    logic signed [31:0] mirror_z;
    logic               last_atom;

    modport source (output valid, orig_x, orig_y, orig_z, mirror_x, mirror_y, mirror_z,
                    last_atom, input ready);
    modport sink   (input valid, orig_x, orig_y, orig_z, mirror_x, mirror_y, mirror_z,
                    last_atom, output ready);
endinterface

interface mfna_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               norm_applied;
    logic               last_out;

    modport source (output valid, out_x, out_y, out_z, norm_applied, last_out, input ready);
    modport sink   (input valid, out_x, out_y, out_z, norm_applied, last_out, output ready);
endinterface

FILE: rtl/mfna_ram.sv
// ============================================================================
// mfna_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ============================================================================
module mfna_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/mfna_div.sv
// ============================================================================
// mfna_div
// Unsigned 64 by 64 restoring divider, one quotient bit per cycle.
// ============================================================================
module mfna_div import mfna_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] quo
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  it_reg;
    logic [64:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] den_reg;
    logic [64:0] rem_sh;
    logic        ge;

    assign rem_sh = {rem_reg[63:0], quo_reg[63]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign done   = done_reg;
    assign quo    = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                it_reg   <= '0;
            end
            else if (busy_reg)
            begin
                it_reg <= it_reg + 6'd1;
                if (it_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_reg <= {quo_reg[62:0], ge};
        end
    end

endmodule

FILE: rtl/mfna_front.sv
// ============================================================================
// mfna_front
// Input side: takes atom words into a two-entry queue for the back end.
// ============================================================================
module mfna_front import mfna_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    mfna_atom_if.sink atom,
    output logic  q_valid,
    input  logic  q_ready,
    output atom_t q_item
);

    atom_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;
    atom_t      in_word;

    assign in_word = '{orig_x: atom.orig_x, orig_y: atom.orig_y, orig_z: atom.orig_z,
                       mirror_x: atom.mirror_x, mirror_y: atom.mirror_y,
                       mirror_z: atom.mirror_z, last_atom: atom.last_atom};

    assign atom.ready = (cnt_reg != 2'd2);
    assign push       = atom.valid && atom.ready;
    assign q_valid    = (cnt_reg != 2'd0);
    assign pop        = q_valid && q_ready;
    assign q_item     = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule

FILE: rtl/mfna_back.sv
// ============================================================================
// mfna_back
// Execution side: rotates and stores atoms, then runs the final pass
// (mean, norm, normalize, average) and drives the result register.
// ============================================================================
module mfna_back import mfna_pkg::*; #(
    parameter int MAX_ATOMS = 64
) (
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  cfg_we,
    input  logic  q_valid,
    output logic  q_ready,
    input  atom_t q_item,
    mfna_result_if.source result
);

    localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CW = $clog2(MAX_ATOMS + 1);
    localparam int RW = 6 * COORD_W;

    back_state_t state_reg, state_next;

    logic [3:0]          step_reg;
    logic                ph_reg;
    logic [1:0]          i_reg;
    logic [1:0]          j_reg;
    logic [CW-1:0]       k_reg;
    logic [CW-1:0]       count_reg;
    logic                mat_ok_reg;
    atom_t               item_reg;
    qarr_t               q_reg;
    logic signed [65:0]  prod_reg;
    logic signed [37:0]  uacc_reg;
    logic signed [31:0]  rot_reg  [3];
    logic signed [39:0]  sums_reg [3];
    logic signed [31:0]  mean_reg [3];
    logic signed [31:0]  val_reg  [3];
    logic [63:0]         acc_reg;
    logic [63:0]         sq_x_reg;
    logic [63:0]         sq_res_reg;
    logic [63:0]         sq_bit_reg;
    logic [35:0]         norm_reg;
    logic                applied_reg;
    logic                out_valid_reg;
    logic signed [31:0]  out_c_reg [3];
    logic                out_applied_reg;
    logic                out_last_reg;

    logic                ram_we;
    logic                ram_rd;
    logic [AW-1:0]       ram_rd_addr;
    logic [RW-1:0]       ram_wdata;
    logic [RW-1:0]       ram_rdata;
    logic                div_start;
    logic                div_done;
    logic [63:0]         div_num;
    logic [63:0]         div_den;
    logic [63:0]         div_quo;
    logic                emit;

    logic signed [32:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic signed [35:0]  rq;
    logic signed [31:0]  uacc_sat;
    logic signed [31:0]  mirror_c [3];
    logic signed [31:0]  rot_rd   [3];
    logic signed [31:0]  orig_rd  [3];
    logic signed [31:0]  avg      [3];
    logic signed [32:0]  dev;
    logic signed [32:0]  dev_mag;
    logic [31:0]         ad;
    logic                s_neg;
    logic [39:0]         s_mag;
    logic                last_k;
    logic [63:0]         sq_sum;
    logic                sq_ge;
    logic signed [31:0]  mean_q;
    logic signed [31:0]  norm_q;

    assign mirror_c[0] = item_reg.mirror_x;
    assign mirror_c[1] = item_reg.mirror_y;
    assign mirror_c[2] = item_reg.mirror_z;

    assign ram_wdata = {item_reg.orig_z, item_reg.orig_y, item_reg.orig_x,
                        rot_reg[2], rot_reg[1], rot_reg[0]};
    assign ram_rd_addr = k_reg[AW-1:0];

    mfna_ram #(.WIDTH(RW), .DEPTH(MAX_ATOMS)) u_store (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(count_reg[AW-1:0]),
        .wr_data(ram_wdata),
        .rd_en  (ram_rd),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rdata)
    );

    mfna_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (div_den),
        .done (div_done),
        .quo  (div_quo)
    );

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            rot_rd[c]  = ram_rdata[c*COORD_W +: COORD_W];
            orig_rd[c] = ram_rdata[(c+3)*COORD_W +: COORD_W];
            avg[c]     = 32'((33'(applied_reg ? val_reg[c] : rot_rd[c]) + 33'(orig_rd[c]))
                             >>> 1);
        end
    end

    assign rq       = rnd30(prod_reg);
    assign uacc_sat = sat32(64'(uacc_reg));
    assign dev      = 33'(rot_rd[j_reg]) - 33'(mean_reg[j_reg]);
    assign dev_mag  = dev[32] ? -dev : dev;
    assign ad       = dev_mag[31:0];
    assign s_neg    = sums_reg[j_reg][39];
    assign s_mag    = s_neg ? 40'(-sums_reg[j_reg]) : 40'(sums_reg[j_reg]);
    assign last_k   = (k_reg + CW'(1)) == count_reg;
    assign sq_sum   = sq_res_reg + sq_bit_reg;
    assign sq_ge    = sq_x_reg >= sq_sum;
    assign mean_q   = s_neg ? -div_quo[31:0] : div_quo[31:0];

    always_comb
    begin
        if (dev[32])
            norm_q = (div_quo > 64'h8000_0000) ? 32'sh80000000 : -div_quo[31:0];
        else
            norm_q = (div_quo > 64'h7fff_ffff) ? 32'sh7fffffff : div_quo[31:0];
    end

    always_comb
    begin
        if (state_reg == ST_MEAN_GO)
        begin
            div_num = 64'(s_mag) + 64'(count_reg >> 1);
            div_den = 64'(count_reg);
        end
        else
        begin
            div_num = {4'b0, ad, 28'b0} + 64'(norm_reg >> 1);
            div_den = 64'(norm_reg);
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MAT:
            begin
                case (step_reg)
                    Q_L2:    begin mul_a = 33'(cfg.quat_l); mul_b = 33'(cfg.quat_l); end
                    Q_M2:    begin mul_a = 33'(cfg.quat_m); mul_b = 33'(cfg.quat_m); end
                    Q_V2:    begin mul_a = 33'(cfg.quat_v); mul_b = 33'(cfg.quat_v); end
                    Q_P2:    begin mul_a = 33'(cfg.quat_p); mul_b = 33'(cfg.quat_p); end
                    Q_LM:    begin mul_a = 33'(cfg.quat_l); mul_b = 33'(cfg.quat_m); end
                    Q_VP:    begin mul_a = 33'(cfg.quat_v); mul_b = 33'(cfg.quat_p); end
                    Q_VL:    begin mul_a = 33'(cfg.quat_v); mul_b = 33'(cfg.quat_l); end
                    Q_MP:    begin mul_a = 33'(cfg.quat_m); mul_b = 33'(cfg.quat_p); end
                    Q_MV:    begin mul_a = 33'(cfg.quat_m); mul_b = 33'(cfg.quat_v); end
                    Q_LP:    begin mul_a = 33'(cfg.quat_l); mul_b = 33'(cfg.quat_p); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            ST_ROT:
            begin
                mul_a = 33'(mat_entry(q_reg, 4'(i_reg) * 4'd3 + 4'(j_reg)));
                mul_b = 33'(mirror_c[i_reg]);
            end
            ST_SCL:
            begin
                mul_a = 33'(uacc_sat);
                mul_b = {2'b00, cfg.scale_factor};
            end
            ST_SQ:
            begin
                mul_a = {1'b0, ad};
                mul_b = {1'b0, ad};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        q_ready    = 1'b0;
        ram_we     = 1'b0;
        ram_rd     = 1'b0;
        div_start  = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    if (count_reg < CW'(MAX_ATOMS))
                        state_next = mat_ok_reg ? ST_ROT : ST_MAT;
                    else if (q_item.last_atom)
                        state_next = ST_MEAN_GO;
                end
            end
            ST_MAT:
                if (ph_reg && step_reg == 4'(NQ - 1))
                    state_next = ST_ROT;
            ST_ROT:
                if (ph_reg && i_reg == 2'd2)
                    state_next = ST_SCL;
            ST_SCL:
                if (ph_reg)
                    state_next = (j_reg == 2'd2) ? ST_WRITE : ST_ROT;
            ST_WRITE:
            begin
                ram_we     = 1'b1;
                state_next = item_reg.last_atom ? ST_MEAN_GO : ST_IDLE;
            end
            ST_MEAN_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
                if (div_done)
                    state_next = (j_reg == 2'd2) ? ST_SQ_RD : ST_MEAN_GO;
            ST_SQ_RD:
            begin
                ram_rd     = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ:
                if (ph_reg && j_reg == 2'd2)
                    state_next = last_k ? ST_SQ_END : ST_SQ_RD;
            ST_SQ_END:
                state_next = ST_SQRT;
            ST_SQRT:
                if (sq_bit_reg[0])
                    state_next = ST_NORM;
            ST_NORM:
                state_next = ST_OUT_RD;
            ST_OUT_RD:
            begin
                ram_rd     = 1'b1;
                state_next = applied_reg ? ST_OUT_GO : ST_EMIT;
            end
            ST_OUT_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
                if (div_done)
                    state_next = (j_reg == 2'd2) ? ST_EMIT : ST_OUT_GO;
            ST_EMIT:
                if (!out_valid_reg || result.ready)
                begin
                    emit       = 1'b1;
                    state_next = last_k ? ST_IDLE : ST_OUT_RD;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mat_ok_reg    <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            ph_reg        <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            for (int c = 0; c < 3; c++)
                sums_reg[c] <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
                mat_ok_reg <= 1'b0;
            else if (state_reg == ST_MAT && ph_reg && step_reg == 4'(NQ - 1))
                mat_ok_reg <= 1'b1;

            if (state_reg == ST_MAT || state_reg == ST_ROT ||
                state_reg == ST_SCL || state_reg == ST_SQ)
                ph_reg <= !ph_reg;
            else
                ph_reg <= 1'b0;

            if (state_reg == ST_IDLE)
            begin
                step_reg <= '0;
                i_reg    <= '0;
                j_reg    <= '0;
            end
            if (state_reg == ST_MAT && ph_reg)
                step_reg <= step_reg + 4'd1;
            if (state_reg == ST_ROT && ph_reg)
                i_reg <= (i_reg == 2'd2) ? 2'd0 : i_reg + 2'd1;
            if (state_reg == ST_SCL && ph_reg)
                j_reg <= (j_reg == 2'd2) ? 2'd0 : j_reg + 2'd1;
            if (state_reg == ST_SQ_RD || state_reg == ST_OUT_RD || state_reg == ST_WRITE)
                j_reg <= '0;
            if (((state_reg == ST_MEAN_WAIT || state_reg == ST_OUT_WAIT) && div_done) ||
                (state_reg == ST_SQ && ph_reg))
                j_reg <= (j_reg == 2'd2) ? 2'd0 : j_reg + 2'd1;

            if (state_reg == ST_MEAN_WAIT && div_done && j_reg == 2'd2)
                k_reg <= '0;
            if ((state_reg == ST_SQ && ph_reg && j_reg == 2'd2) || emit)
                k_reg <= last_k ? '0 : k_reg + CW'(1);

            if (state_reg == ST_WRITE)
            begin
                count_reg <= count_reg + CW'(1);
                for (int c = 0; c < 3; c++)
                    sums_reg[c] <= sums_reg[c] + 40'(rot_reg[c]);
            end
            else if (emit && last_k)
            begin
                count_reg <= '0;
                for (int c = 0; c < 3; c++)
                    sums_reg[c] <= '0;
            end

            if (emit)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (state_reg == ST_IDLE && q_valid)
            item_reg <= q_item;

        if (state_reg == ST_MAT && ph_reg)
            q_reg[step_reg] <= rq[34:0];

        if (state_reg == ST_ROT && ph_reg)
            uacc_reg <= ((i_reg == 2'd0) ? 38'sd0 : uacc_reg) + 38'(rq);

        if (state_reg == ST_SCL && ph_reg)
            rot_reg[j_reg] <= sat32(64'(rq));

        if (state_reg == ST_MEAN_WAIT && div_done)
            mean_reg[j_reg] <= mean_q;

        if (state_reg == ST_MEAN_WAIT && div_done && j_reg == 2'd2)
            acc_reg <= '0;
        else if (state_reg == ST_SQ && ph_reg)
            acc_reg <= acc_reg + {8'b0, prod_reg[63:8]};

        if (state_reg == ST_SQ_END)
        begin
            sq_x_reg   <= acc_reg;
            sq_res_reg <= '0;
            sq_bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (state_reg == ST_SQRT)
        begin
            if (sq_ge)
            begin
                sq_x_reg   <= sq_x_reg - sq_sum;
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end
            else
            begin
                sq_res_reg <= sq_res_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end

        if (state_reg == ST_NORM)
        begin
            norm_reg    <= {sq_res_reg[31:0], 4'b0};
            applied_reg <= (sq_res_reg[31:0] != 32'd0) &&
                           ({sq_res_reg[31:0], 4'b0} >= 36'(cfg.min_norm));
        end

        if (state_reg == ST_OUT_WAIT && div_done)
            val_reg[j_reg] <= norm_q;

        if (emit)
        begin
            for (int c = 0; c < 3; c++)
                out_c_reg[c] <= avg[c];
            out_applied_reg <= applied_reg;
            out_last_reg    <= last_k;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.out_x        = out_c_reg[0];
    assign result.out_y        = out_c_reg[1];
    assign result.out_z        = out_c_reg[2];
    assign result.norm_applied = out_applied_reg;
    assign result.last_out     = out_last_reg;

endmodule

FILE: rtl/mirror_fold_normalize_average.sv
// ============================================================================
// mirror_fold_normalize_average
// Rotates and scales mirrored atoms, then centers, normalizes and averages
// the set against the original atoms once the final atom arrives.
// ============================================================================
//
//  channel   direction  word                                   accepted when
//  -------   ---------  -------------------------------------  ---------------
//  atom      in         orig_x/y/z, mirror_x/y/z, last_atom    valid && ready
//  result    out        out_x/y/z, norm_applied, last_out      valid && ready
//  cfg       in         cfg_idx, cfg_data                      cfg_we
//
//  Each atom is rotated and scaled in the back end on one shared 33x33
//  signed multiplier with a registered product; the matrix is rebuilt
//  after any configuration write. The final pass divides for the means,
//  sums the squared deviations, takes the root, and per atom runs three
//  divisions when normalizing.
//  Reset clears control state and the running sums and loads configuration
//  defaults; the atom store needs no clearing. A two-word queue holds incoming
//  atoms while the back end is busy; a stalled result register blocks the back
//  end, and the atom channel once the queue is full.
module mirror_fold_normalize_average import mfna_pkg::*; #(
    parameter int MAX_ATOMS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    mfna_atom_if.sink   atom,
    mfna_result_if.source result,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [31:0] cfg_data
);

    cfg_t  cfg_reg;
    logic  q_valid;
    logic  q_ready;
    atom_t q_item;

    // configuration registers; unknown indexes drop the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quat_l       <= '0;
            cfg_reg.quat_m       <= '0;
            cfg_reg.quat_v       <= '0;
            cfg_reg.quat_p       <= 32'sh40000000;
            cfg_reg.scale_factor <= 31'h40000000;
            cfg_reg.min_norm     <= 31'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_idx))
                CFG_QUAT_L:   cfg_reg.quat_l       <= cfg_data;
                CFG_QUAT_M:   cfg_reg.quat_m       <= cfg_data;
                CFG_QUAT_V:   cfg_reg.quat_v       <= cfg_data;
                CFG_QUAT_P:   cfg_reg.quat_p       <= cfg_data;
                CFG_SCALE:    cfg_reg.scale_factor <= cfg_data[30:0];
                CFG_MIN_NORM: cfg_reg.min_norm     <= cfg_data[30:0];
                default:      ;
            endcase
        end
    end

    // front end: queue atoms
    mfna_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .atom   (atom),
        .q_valid(q_valid),
        .q_ready(q_ready),
        .q_item (q_item)
    );

    // back end: rotate, store, final pass, result register
    mfna_back #(.MAX_ATOMS(MAX_ATOMS)) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .cfg_we (cfg_we),
        .q_valid(q_valid),
        .q_ready(q_ready),
        .q_item (q_item),
        .result (result)
    );

endmodule

FILE: rtl/mfna_chk.sv
// ============================================================================
// mfna_chk
// Port-level checks on the result channel, bound to the top level.
// ============================================================================
module mfna_chk (
    input logic clk,
    input logic rst_n,
    input logic res_valid,
    input logic res_ready,
    input logic res_applied,
    input logic res_last,
    input logic [31:0] res_x
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result valid dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_x) && $stable(res_last))
        else $error("result word changed while stalled");

    a_applied_const: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last |=>
            !res_valid || res_applied == $past(res_applied))
        else $error("norm_applied changed within a set");

endmodule

bind mirror_fold_normalize_average mfna_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_applied(result.norm_applied),
    .res_last   (result.last_out),
    .res_x      (result.out_x)
);
